### src/cfr_pkg.sv
// Package for the constant fold and reduce unit: codes and shared types.
// Depends on nothing; used by every module in src.
package cfr_pkg;

    localparam logic [4:0] FN_ADD    = 5'd0;
    localparam logic [4:0] FN_PTRADD = 5'd1;
    localparam logic [4:0] FN_SUB    = 5'd2;
    localparam logic [4:0] FN_MUL    = 5'd3;
    localparam logic [4:0] FN_DIV    = 5'd4;
    localparam logic [4:0] FN_MOD    = 5'd5;
    localparam logic [4:0] FN_AND    = 5'd6;
    localparam logic [4:0] FN_OR     = 5'd7;
    localparam logic [4:0] FN_XOR    = 5'd8;
    localparam logic [4:0] FN_SHL    = 5'd9;
    localparam logic [4:0] FN_SHR    = 5'd10;
    localparam logic [4:0] FN_EQ     = 5'd11;
    localparam logic [4:0] FN_NE     = 5'd12;
    localparam logic [4:0] FN_LT     = 5'd13;
    localparam logic [4:0] FN_GT     = 5'd14;
    localparam logic [4:0] FN_LE     = 5'd15;
    localparam logic [4:0] FN_GE     = 5'd16;
    localparam logic [4:0] FN_NOT    = 5'd17;
    localparam logic [4:0] FN_LOGNOT = 5'd18;
    localparam logic [4:0] FN_NEG    = 5'd19;
    localparam logic [4:0] FN_SCALE  = 5'd20;

    localparam logic [2:0] ACT_KEEP  = 3'd0;
    localparam logic [2:0] ACT_LIT   = 3'd1;
    localparam logic [2:0] ACT_LEFT  = 3'd2;
    localparam logic [2:0] ACT_RIGHT = 3'd3;
    localparam logic [2:0] ACT_NEGR  = 3'd4;
    localparam logic [2:0] ACT_LSHL  = 3'd5;
    localparam logic [2:0] ACT_LSHR  = 3'd6;
    localparam logic [2:0] ACT_RSHL  = 3'd7;

    localparam logic [30:0] ADD_LIMIT_RESET = 31'h4000_0000;

    // Request carried along the chain of cells
    typedef struct packed {
        logic [4:0]  func;
        logic [31:0] a;
        logic [31:0] b;
        logic        cl;
        logic        cr;
    } node_t;

    // Partial verdict handed from cell to cell
    typedef struct packed {
        logic        done;
        logic [2:0]  action;
        logic [31:0] lit;
        logic [5:0]  sh;
    } verdict_t;

endpackage

### src/cfr_cell.sv
// Pipeline cell of the fold and reduce chain: register stage gated by advance.
// Depends on cfr_pkg.
module cfr_cell
    import cfr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  logic     valid_in,
    input  node_t    node_in,
    input  verdict_t verd_in,
    output logic     valid_out,
    output node_t    node_out,
    output verdict_t verd_out
);
    logic     valid_reg;
    node_t    node_reg;
    verdict_t verd_reg;

    // Hold control under reset, advance when the chain moves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            node_reg <= node_in;
            verd_reg <= verd_in;
        end
    end

    assign valid_out = valid_reg;
    assign node_out  = node_reg;
    assign verd_out  = verd_reg;
endmodule

### src/cfr_divider.sv
// Signed 32-bit divider as a chain of restoring cells, one quotient bit per cell.
// Depends on cfr_pkg.
module cfr_divider
    import cfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] quot,
    output logic [31:0] rem
);
    logic [31:0] num_reg  [0:32];
    logic [31:0] den_reg  [0:32];
    logic [31:0] r_reg    [0:32];
    logic [31:0] q_reg    [0:32];
    logic        qneg_reg [0:32];
    logic        rneg_reg [0:32];

    // Load magnitudes into the first cell
    always_ff @(posedge aclk) begin
        if (advance) begin
            num_reg[0]  <= a[31] ? 32'd0 - a : a;
            den_reg[0]  <= b[31] ? 32'd0 - b : b;
            r_reg[0]    <= 32'd0;
            q_reg[0]    <= 32'd0;
            qneg_reg[0] <= a[31] ^ b[31];
            rneg_reg[0] <= a[31];
        end
    end

    // Each cell retires one quotient bit, msb first
    for (genvar k = 0; k < 32; k++) begin : g_cell
        logic [32:0] trial;
        logic [32:0] diff;
        assign trial = {r_reg[k], num_reg[k][31 - k]};
        assign diff  = trial - {1'b0, den_reg[k]};
        always_ff @(posedge aclk) begin
            if (advance) begin
                num_reg[k+1]  <= num_reg[k];
                den_reg[k+1]  <= den_reg[k];
                qneg_reg[k+1] <= qneg_reg[k];
                rneg_reg[k+1] <= rneg_reg[k];
                if (!diff[32]) begin
                    r_reg[k+1] <= diff[31:0];
                    q_reg[k+1] <= q_reg[k] | (32'd1 << (31 - k));
                end else begin
                    r_reg[k+1] <= trial[31:0];
                    q_reg[k+1] <= q_reg[k];
                end
            end
        end
    end

    assign quot = qneg_reg[32] ? 32'd0 - q_reg[32] : q_reg[32];
    assign rem  = rneg_reg[32] ? 32'd0 - r_reg[32] : r_reg[32];
endmodule

### src/constant_fold_reduce_unit.sv
// Top level of the constant fold and reduce unit.
// Depends on cfr_pkg, cfr_cell and cfr_divider.
// Throughput one request per cycle while the result is not held at the output.
// The chain length is set by the 32-cell divider; other folds ride along in cells.
// Output register parts the sides; the chain stalls only when the result is held.
// Reset (aresetn low, synchronous) empties the chain and sets add_limit to 2^30.
module constant_fold_reduce_unit
    import cfr_pkg::*;
#(
    parameter int WORD_BYTES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [4:0]         s_func,
    input  logic signed [31:0] s_left_value,
    input  logic signed [31:0] s_right_value,
    input  logic               s_left_is_lit,
    input  logic               s_right_is_lit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_action,
    output logic signed [31:0] m_literal_value,
    output logic [5:0]         m_shift_amount
);
    localparam int MAXSH = WORD_BYTES * 8 - 1;
    localparam int NCELL = 33;

    logic [30:0] add_limit_reg;
    logic        advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_limit_reg <= ADD_LIMIT_RESET;
        end else if (cfg_we) begin
            add_limit_reg <= cfg_wdata;
        end
    end

    // Front-end verdict; literal division and remainder are settled at the tail
    node_t    n0;
    verdict_t v0;
    logic [31:0] a, b, mag_a, mag_b, sum, shl_r, shr_r, mmask;
    logic [32:0] wide;
    logic [63:0] prod;
    logic        bad_shift;
    logic [4:0]  sa;
    logic [5:0]  il, ir;
    logic        hl, hr;

    assign n0 = '{func: s_func, a: s_left_value, b: s_right_value,
                  cl: s_left_is_lit, cr: s_right_is_lit};
    assign a = s_left_value;
    assign b = s_right_value;
    assign mag_a = a[31] ? 32'd0 - a : a;
    assign mag_b = b[31] ? 32'd0 - b : b;
    assign wide = (s_func == FN_SUB) ? {a[31], a} - {b[31], b} : {a[31], a} + {b[31], b};
    assign sum = wide[31:0];
    assign bad_shift = b[31] || (b > 32'(MAXSH));
    assign sa = (b > 32'd31) ? 5'd31 : b[4:0];
    assign shl_r = (b > 32'd31) ? 32'd0 : a << sa;
    assign shr_r = 32'($signed(a) >>> sa);
    assign mmask = {1'b0, add_limit_reg} - 32'd1;

    // Power of two exponent below the search bound; positive values only
    always_comb begin
        hl = 1'b0;
        hr = 1'b0;
        il = '0;
        ir = '0;
        for (int i = MAXSH - 1; i >= 0; i--) begin
            if (i < 31 && a == (32'd1 << i)) begin
                hl = 1'b1;
                il = 6'(i);
            end
            if (i < 31 && b == (32'd1 << i)) begin
                hr = 1'b1;
                ir = 6'(i);
            end
        end
    end

    always_comb begin
        logic folded;
        logic [31:0] lit;
        logic isadd;
        logic bl, br;
        folded = 1'b0;
        lit    = '0;
        isadd  = (s_func == FN_ADD) || (s_func == FN_PTRADD);
        prod   = 64'($signed(a) * $signed(b));
        v0     = '{done: 1'b1, action: ACT_KEEP, lit: 32'd0, sh: 6'd0};
        if (s_left_is_lit && s_right_is_lit) begin
            unique case (s_func)
                FN_ADD, FN_PTRADD, FN_SUB: begin
                    folded = ({1'b0, mag_a} < {2'b0, add_limit_reg})
                          && ({1'b0, mag_b} < {2'b0, add_limit_reg})
                          && (wide[32] == wide[31]);
                    lit = sum;
                end
                FN_MUL: begin
                    folded = (prod[63:31] == {33{prod[31]}})
                          && ((prod[31:0] & mmask) == prod[31:0]);
                    lit = prod[31:0];
                end
                FN_AND:  begin folded = 1'b1; lit = a & b; end
                FN_OR:   begin folded = 1'b1; lit = a | b; end
                FN_XOR:  begin folded = 1'b1; lit = a ^ b; end
                FN_SHL:  begin folded = !bad_shift; lit = shl_r; end
                FN_SHR:  begin folded = !bad_shift; lit = shr_r; end
                FN_EQ:   begin folded = 1'b1; lit = 32'(a == b); end
                FN_NE:   begin folded = 1'b1; lit = 32'(a != b); end
                FN_LT:   begin folded = 1'b1; lit = 32'($signed(a) < $signed(b)); end
                FN_GT:   begin folded = 1'b1; lit = 32'($signed(a) > $signed(b)); end
                FN_LE:   begin folded = 1'b1; lit = 32'($signed(a) <= $signed(b)); end
                FN_GE:   begin folded = 1'b1; lit = 32'($signed(a) >= $signed(b)); end
                default: begin folded = 1'b0; lit = '0; end
            endcase
        end else if (s_left_is_lit) begin
            unique case (s_func)
                FN_NOT:    begin folded = 1'b1; lit = ~a; end
                FN_LOGNOT: begin folded = 1'b1; lit = 32'(a == 32'd0); end
                FN_NEG:    begin folded = 1'b1; lit = 32'd0 - a; end
                FN_SCALE:  begin folded = 1'b1; lit = 32'(a * 32'(WORD_BYTES)); end
                default:   begin folded = 1'b0; lit = '0; end
            endcase
        end
        // Division folds late; mark undecided so the tail cell resolves it
        if (s_left_is_lit && s_right_is_lit
            && (s_func == FN_DIV || s_func == FN_MOD)
            && b != 32'd0 && !(a == 32'h8000_0000 && b == 32'hFFFF_FFFF)) begin
            v0.done = 1'b0;
        end
        bl = hl && s_left_is_lit && (s_func == FN_MUL);
        br = hr && s_right_is_lit;
        if (folded) begin
            v0.action = ACT_LIT;
            v0.lit    = lit;
        end else if (isadd && s_right_is_lit && b == 32'd0) begin
            v0.action = ACT_LEFT;
        end else if (isadd && s_left_is_lit && a == 32'd0) begin
            v0.action = ACT_RIGHT;
        end else if (s_func == FN_SUB && s_right_is_lit && b == 32'd0) begin
            v0.action = ACT_LEFT;
        end else if (s_func == FN_SUB && s_left_is_lit && a == 32'd0) begin
            v0.action = ACT_NEGR;
        end else if (s_func == FN_MUL && ((s_left_is_lit && a == 32'd0)
                     || (s_right_is_lit && b == 32'd0))) begin
            v0.action = ACT_LIT;
        end else if (s_func == FN_MUL || s_func == FN_DIV) begin
            if (br && (!bl || ir <= il)) begin
                v0.action = (s_func == FN_MUL) ? ACT_LSHL : ACT_LSHR;
                v0.sh     = ir;
            end else if (bl) begin
                v0.action = ACT_RSHL;
                v0.sh     = il;
            end
        end
    end

    // Chain of cells carrying request and verdict alongside the divider
    logic     cv [0:NCELL];
    node_t    cn [0:NCELL];
    verdict_t cvd[0:NCELL];
    assign cv[0]  = s_valid;
    assign cn[0]  = n0;
    assign cvd[0] = v0;

    for (genvar k = 0; k < NCELL; k++) begin : g_chain
        cfr_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .valid_in  (cv[k]),
            .node_in   (cn[k]),
            .verd_in   (cvd[k]),
            .valid_out (cv[k+1]),
            .node_out  (cn[k+1]),
            .verd_out  (cvd[k+1])
        );
    end

    logic [31:0] quot, rem;
    cfr_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .a       (s_left_value),
        .b       (s_right_value),
        .quot    (quot),
        .rem     (rem)
    );
    // Divider output aligns with cell 33 (33 register stages)

    verdict_t vfin;
    always_comb begin
        vfin = cvd[33];
        if (!cvd[33].done) begin
            vfin.action = ACT_LIT;
            vfin.lit    = (cn[33].func == FN_DIV) ? quot : rem;
            vfin.sh     = 6'd0;
        end
    end

    // Output register; chain holds while a result waits
    logic        out_valid_reg;
    verdict_t    out_reg;
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= cv[33];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= vfin;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_action        = out_reg.action;
    assign m_literal_value = out_reg.lit;
    assign m_shift_amount  = out_reg.sh;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_literal_value))
        else $error("result changed while held");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("chain stalled with empty output");
    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action != ACT_LSHL && m_action != ACT_LSHR
        && m_action != ACT_RSHL |-> m_shift_amount == 6'd0)
        else $error("shift amount without shift action");
endmodule

### tb/constant_fold_reduce_unit_check.sv
// Checker for the constant fold and reduce unit: predicts each result from the
// accepted request and compares it field by field. Depends on cfr_pkg.
module constant_fold_reduce_unit_check
    import cfr_pkg::*;
#(
    parameter int WORD_BYTES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [4:0]         s_func,
    input  logic signed [31:0] s_left_value,
    input  logic signed [31:0] s_right_value,
    input  logic               s_left_is_lit,
    input  logic               s_right_is_lit,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [2:0]         m_action,
    input  logic signed [31:0] m_literal_value,
    input  logic [5:0]         m_shift_amount,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] lit;
        logic [5:0]  sh;
    } rewrite_t;

    localparam int MAXSH = WORD_BYTES * 8 - 1;

    logic [30:0] limit_q;
    rewrite_t    rewrite_q[$];

    // Exponent of a positive power of two below the search bound, or -1
    function automatic int pow2_exp(logic signed [31:0] v);
        if (v <= 0 || (v & (v - 1)) != 0) return -1;
        for (int i = 0; i < MAXSH; i++)
            if (v == (32'sd1 <<< i)) return i;
        return -1;
    endfunction

    function automatic rewrite_t fold_node(logic [4:0] f, logic signed [31:0] a,
                                           logic signed [31:0] b, logic cl, logic cr,
                                           logic [30:0] lim);
        rewrite_t r;
        logic done;
        logic signed [63:0] w;
        logic [31:0] ma, mb, lim32;
        int ir, il;
        logic isadd;
        r = '0;
        done = 1'b0;
        lim32 = {1'b0, lim};
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        isadd = (f == FN_ADD || f == FN_PTRADD);
        if (cl && cr) begin
            case (f)
                FN_ADD, FN_PTRADD, FN_SUB: begin
                    w = (f == FN_SUB) ? (64'(a) - 64'(b)) : (64'(a) + 64'(b));
                    if (ma < lim32 && mb < lim32 && w == 64'(signed'(w[31:0]))) begin
                        r.lit = w[31:0]; done = 1'b1;
                    end
                end
                FN_MUL: begin
                    w = 64'(a) * 64'(b);
                    if (w == 64'(signed'(w[31:0])) &&
                        ((w[31:0] & (lim32 - 32'd1)) == w[31:0])) begin
                        r.lit = w[31:0]; done = 1'b1;
                    end
                end
                FN_DIV, FN_MOD: begin
                    if (b != 0 && !(a == 32'sh8000_0000 && b == -1)) begin
                        r.lit = (f == FN_DIV) ? a / b : a % b; done = 1'b1;
                    end
                end
                FN_AND: begin r.lit = a & b; done = 1'b1; end
                FN_OR:  begin r.lit = a | b; done = 1'b1; end
                FN_XOR: begin r.lit = a ^ b; done = 1'b1; end
                FN_SHL, FN_SHR: begin
                    if (b >= 0 && b <= MAXSH) begin
                        if (f == FN_SHL) r.lit = (b >= 32) ? 32'd0 : a << b;
                        else r.lit = a >>> ((b > 31) ? 31 : b);
                        done = 1'b1;
                    end
                end
                FN_EQ: begin r.lit = 32'(a == b); done = 1'b1; end
                FN_NE: begin r.lit = 32'(a != b); done = 1'b1; end
                FN_LT: begin r.lit = 32'(a < b);  done = 1'b1; end
                FN_GT: begin r.lit = 32'(a > b);  done = 1'b1; end
                FN_LE: begin r.lit = 32'(a <= b); done = 1'b1; end
                FN_GE: begin r.lit = 32'(a >= b); done = 1'b1; end
                default: ;
            endcase
        end else if (cl) begin
            case (f)
                FN_NOT:    begin r.lit = ~a; done = 1'b1; end
                FN_LOGNOT: begin r.lit = 32'(a == 0); done = 1'b1; end
                FN_NEG:    begin r.lit = -a; done = 1'b1; end
                FN_SCALE:  begin r.lit = a * WORD_BYTES; done = 1'b1; end
                default: ;
            endcase
        end
        if (done) begin
            r.action = ACT_LIT;
            return r;
        end
        // Not folded: look for identities and shift reductions
        r.lit = '0;
        if (isadd && cr && b == 0) r.action = ACT_LEFT;
        else if (isadd && cl && a == 0) r.action = ACT_RIGHT;
        else if (f == FN_SUB && cr && b == 0) r.action = ACT_LEFT;
        else if (f == FN_SUB && cl && a == 0) r.action = ACT_NEGR;
        else if (f == FN_MUL && ((cl && a == 0) || (cr && b == 0))) r.action = ACT_LIT;
        else if (f == FN_MUL || f == FN_DIV) begin
            ir = cr ? pow2_exp(b) : -1;
            il = (cl && f == FN_MUL) ? pow2_exp(a) : -1;
            if (ir >= 0 && (il < 0 || ir <= il)) begin
                r.action = (f == FN_MUL) ? ACT_LSHL : ACT_LSHR;
                r.sh = 6'(ir);
            end else if (il >= 0) begin
                r.action = ACT_RSHL;
                r.sh = 6'(il);
            end
        end
        return r;
    endfunction

    assign pending = rewrite_q.size();

    always @(posedge aclk) begin
        rewrite_t want;
        if (!aresetn) begin
            limit_q <= ADD_LIMIT_RESET;
            fail_count <= 0;
            rewrite_q.delete();
        end else begin
            if (cfg_we) limit_q <= cfg_wdata;
            // Predict for each accepted request
            if (s_valid && s_ready)
                rewrite_q.push_back(fold_node(s_func, s_left_value, s_right_value,
                                              s_left_is_lit, s_right_is_lit, limit_q));
            // Compare each accepted result with the oldest prediction
            if (m_valid && m_ready) begin
                if (rewrite_q.size() == 0) begin
                    $display("%0t: unexpected result action=%0d lit=%0d sh=%0d", $time,
                             m_action, m_literal_value, m_shift_amount);
                    fail_count <= fail_count + 1;
                end else begin
                    want = rewrite_q.pop_front();
                    if (want.action !== m_action || want.lit !== m_literal_value ||
                        want.sh !== m_shift_amount) begin
                        $display("%0t: mismatch expected action=%0d lit=%0d sh=%0d, got action=%0d lit=%0d sh=%0d",
                                 $time, want.action, $signed(want.lit), want.sh,
                                 m_action, m_literal_value, m_shift_amount);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/constant_fold_reduce_unit_test.sv
// Testbench top: clock, reset, requests, configuration and verdict.
// Depends on cfr_pkg, constant_fold_reduce_unit, constant_fold_reduce_unit_check.
module constant_fold_reduce_unit_test;
    import cfr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 34;
    localparam int STALL_MAX = 20000;

    logic               aclk, aresetn;
    logic               cfg_we;
    logic [30:0]        cfg_wdata;
    logic               s_valid, s_ready;
    logic [4:0]         s_func;
    logic signed [31:0] s_left_value, s_right_value;
    logic               s_left_is_lit, s_right_is_lit;
    logic               m_valid, m_ready;
    logic [2:0]         m_action;
    logic signed [31:0] m_literal_value;
    logic [5:0]         m_shift_amount;
    int                 fail_count, pending;

    int  send_idle_pct, recv_idle_pct;
    bit  hold_off;
    int  quiet_cycles;

    constant_fold_reduce_unit #(.WORD_BYTES(4)) uut (.*);
    constant_fold_reduce_unit_check #(.WORD_BYTES(4)) checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Receiver: random back-pressure, or a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) m_ready <= 1'b0;
            else m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_MAX) begin
            $display("[constant_fold_reduce_unit] ERROR");
            $finish;
        end else quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'(signed'($urandom_range(8)) - 4);
            1: return 32'sd1 <<< $urandom_range(31);
            2: return -(32'sd1 <<< $urandom_range(31));
            3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            4: return 32'(signed'($urandom_range(80)) - 20);
            5: return 32'(signed'($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    // Idle with valid low, then offer the request until it is taken
    task automatic send_node(logic [4:0] f, logic signed [31:0] a, logic signed [31:0] b,
                             logic cl, logic cr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_left_value <= a;
        s_right_value <= b;
        s_left_is_lit <= cl;
        s_right_is_lit <= cr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random();
        logic [4:0] f;
        f = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(21));
        send_node(f, pick_value(), pick_value(), $urandom_range(3) != 0,
                  $urandom_range(3) != 0);
    endtask

    // Wait for every result, then the pipeline depth, before touching the register
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic set_limit(logic [30:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [30:0] limits[6];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_func = '0;
        s_left_value = '0;
        s_right_value = '0;
        s_left_is_lit = 1'b0;
        s_right_is_lit = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        limits = '{31'h4000_0000, 31'h7FFF_FFFF, 31'd1, 31'd0, 31'd1024, 31'h0001_0000};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, every operator, guarded folds
        for (int f = 0; f < 22; f++)
            send_node(5'(f), 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b1);
        send_node(FN_MUL, 32'sd0, 32'sh7FFF_FFFF, 1'b1, 1'b0);
        send_node(FN_DIV, 32'sh8000_0000, -32'sd1, 1'b1, 1'b1);
        send_node(FN_MOD, 32'sd7, 32'sd0, 1'b1, 1'b1);
        send_node(FN_SHL, 32'sd5, -32'sd1, 1'b1, 1'b1);
        send_node(FN_SHR, -32'sd5, 32'sd31, 1'b1, 1'b1);
        send_node(FN_NEG, 32'sh8000_0000, 32'sd0, 1'b1, 1'b0);
        send_node(FN_MUL, 32'sd8, 32'sd8, 1'b1, 1'b1);
        send_node(5'd31, 32'sd0, 32'sd0, 1'b1, 1'b1);
        drain();

        // Random phases over several limits and idling patterns
        for (int p = 0; p < 6; p++) begin
            set_limit(limits[p]);
            case (p % 3)
                0: begin send_idle_pct = 27; recv_idle_pct = 81; end
                1: begin send_idle_pct = 81; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (p == 2) begin
                // Hold the receiver off long enough to back up the pipeline
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                    repeat (120) send_random();
                join
            end
            repeat (180) send_random();
            drain();
        end

        if (fail_count == 0) $display("[constant_fold_reduce_unit] OK");
        else $display("[constant_fold_reduce_unit] ERROR");
        $finish;
    end
endmodule
